@@ hw/rtl/uebd_pkg.sv @@
// Package for the epoch to BCD date/time converter.
// Holds the fixed arithmetic constants, the month table and the BCD helper.
// No dependencies.
package uebd_pkg;

    // Seconds per day and its fixed-point reciprocal (floor of 2^48 / 86400).
    localparam logic [16:0] SECS_PER_DAY = 17'd86400;
    localparam logic [31:0] DAY_RECIP    = 32'd3257812230;
    localparam int          DAY_SHIFT    = 48;

    // Seconds per hour and floor of 2^24 / 3600.
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [12:0] HOUR_RECIP    = 13'd4660;

    // Seconds per minute and floor of 2^18 / 60.
    localparam logic [5:0]  SECS_PER_MIN = 6'd60;
    localparam logic [12:0] MIN_RECIP    = 13'd4369;

    // Days per four-year cycle and floor of 2^24 / 1461.
    localparam logic [10:0] QUAD_DAYS  = 11'd1461;
    localparam logic [13:0] QUAD_RECIP = 14'd11483;

    // Days per week and floor of 2^19 / 7.
    localparam logic [2:0]  WEEK_DAYS  = 3'd7;
    localparam logic [16:0] WEEK_RECIP = 17'd74898;

    // 1970-01-01 was a Thursday; the day index is offset so Sunday maps to 0.
    localparam logic [2:0]  WEEK_OFFSET = 3'd4;

    // Bounds of the supported range: 2000-01-01 (first instant) and 2100-01-01 (first instant past it).
    localparam logic [31:0] EPOCH_Y2000 = 32'd946684800;
    localparam logic [31:0] EPOCH_Y2100 = 32'd4102444800;
    localparam logic [15:0] DAYS_Y2000  = 16'd10957;

    // Day-of-year boundaries inside a four-year cycle that starts with a leap year.
    localparam logic [10:0] QUAD_Y1 = 11'd366;
    localparam logic [10:0] QUAD_Y2 = 11'd731;
    localparam logic [10:0] QUAD_Y3 = 11'd1096;

    // First day of each month (0-based) in a common year.
    localparam logic [8:0] MONTH_START [0:11] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    // Converts a value below 100 into two packed BCD digits.
    function automatic logic [7:0] to_bcd(input logic [7:0] v);
        logic [15:0] prod;
        logic [3:0]  tens;
        logic [7:0]  ones;
        prod = 16'(v) * 16'd205;
        tens = prod[14:11];
        ones = v - 8'(tens) * 8'd10;
        return {tens, ones[3:0]};
    endfunction

endpackage

@@ hw/rtl/uebd_if.sv @@
// Channel interfaces of the epoch to BCD date/time converter.
// The epoch channel carries the input count, the RTC channel the register image.
// No dependencies.
interface uebd_epoch_if;
    logic        valid;
    logic        ready;
    logic [31:0] epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink (input valid, input epoch_seconds, output ready);
endinterface

interface uebd_rtc_if;
    logic       valid;
    logic       ready;
    logic [6:0] seconds_bcd;
    logic [6:0] minutes_bcd;
    logic [5:0] hours_bcd;
    logic [2:0] weekday_bcd;
    logic [5:0] date_bcd;
    logic [4:0] month_bcd;
    logic [7:0] year_bcd;
    logic       range_error;

    modport source (
        output valid, output seconds_bcd, output minutes_bcd, output hours_bcd,
        output weekday_bcd, output date_bcd, output month_bcd, output year_bcd,
        output range_error, input ready
    );
    modport sink (
        input valid, input seconds_bcd, input minutes_bcd, input hours_bcd,
        input weekday_bcd, input date_bcd, input month_bcd, input year_bcd,
        input range_error, output ready
    );
endinterface

@@ hw/rtl/unix_epoch_to_bcd_datetime.sv @@
// Epoch to BCD date/time converter, top level.
// Depends on uebd_pkg and the channel interfaces in uebd_if.sv.
//
// Usage: each transaction on the epoch channel carries a 32-bit count of
// seconds since 1970-01-01 00:00:00 UTC. For each one the block returns one
// transaction on the rtc channel holding BCD seconds, minutes, 24-hour hours,
// weekday (Sunday is 1), date, month and two-digit year after 2000.
// Instants outside the years 2000 to 2099 set range_error and zero all fields.
// The converter is a seven-stage pipeline with a register after every stage;
// the stage 7 registers drive the rtc channel.
// One epoch is accepted every cycle unless the receiver stalls the output.
// The depth is set by the chain of reciprocal multiplies, each followed by a
// one-step remainder correction, plus the month search and BCD packing.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and epoch.ready drops in the same cycle; nothing is lost or repeated.
// Reset clears all stage valid bits, so no result is presented after reset.
module unix_epoch_to_bcd_datetime (
    input  logic            clk,
    input  logic            rst_n,
    uebd_epoch_if.sink      epoch,
    uebd_rtc_if.source      rtc
);

    // Pipeline advance: move when the output is empty or being taken.
    logic advance;
    assign advance     = !rtc.valid || rtc.ready;
    assign epoch.ready = advance;

    // Stage valid bits.
    logic [6:0] valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[5:0], epoch.valid};
        end
    end

    // Stage 1: day estimate by reciprocal multiply, range check.
    logic [63:0] day_prod;
    logic [15:0] day_est_next, day_est_reg;
    logic        err1_next, err1_reg;
    logic [31:0] epoch1_reg;

    always_comb
    begin
        day_prod     = 64'(epoch.epoch_seconds) * 64'(uebd_pkg::DAY_RECIP);
        day_est_next = day_prod[uebd_pkg::DAY_SHIFT +: 16];
        err1_next    = (epoch.epoch_seconds < uebd_pkg::EPOCH_Y2000)
                    || (epoch.epoch_seconds >= uebd_pkg::EPOCH_Y2100);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            epoch1_reg  <= epoch.epoch_seconds;
            day_est_reg <= day_est_next;
            err1_reg    <= err1_next;
        end
    end

    // Stage 2: correct the day count and derive the second of the day.
    logic [32:0] day_rem;
    logic [15:0] days_next, days_reg;
    logic [16:0] sod_next, sod_reg;
    logic        err2_reg;

    always_comb
    begin
        day_rem = {1'b0, epoch1_reg} - 33'(day_est_reg) * 33'(uebd_pkg::SECS_PER_DAY);
        if (day_rem >= 33'(uebd_pkg::SECS_PER_DAY))
        begin
            days_next = day_est_reg + 16'd1;
            sod_next  = 17'(day_rem - 33'(uebd_pkg::SECS_PER_DAY));
        end
        else
        begin
            days_next = day_est_reg;
            sod_next  = 17'(day_rem);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            days_reg <= days_next;
            sod_reg  <= sod_next;
            err2_reg <= err1_reg;
        end
    end

    // Stage 3: estimates of hour, four-year cycle and week quotient.
    logic [29:0] hour_prod;
    logic [29:0] quad_prod;
    logic [33:0] week_prod;
    logic [15:0] dsince_next, dsince_reg;
    logic [16:0] wdx_next, wdx_reg;
    logic [4:0]  hh_est_next, hh_est_reg;
    logic [5:0]  quad_est_next, quad_est_reg;
    logic [14:0] wq_est_next, wq_est_reg;
    logic [16:0] sod3_reg;
    logic        err3_reg;

    always_comb
    begin
        hour_prod     = 30'(sod_reg) * 30'(uebd_pkg::HOUR_RECIP);
        hh_est_next   = hour_prod[28:24];
        dsince_next   = days_reg - uebd_pkg::DAYS_Y2000;
        quad_prod     = 30'(dsince_next) * 30'(uebd_pkg::QUAD_RECIP);
        quad_est_next = quad_prod[29:24];
        wdx_next      = 17'(days_reg) + 17'(uebd_pkg::WEEK_OFFSET);
        week_prod     = 34'(wdx_next) * 34'(uebd_pkg::WEEK_RECIP);
        wq_est_next   = week_prod[33:19];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sod3_reg     <= sod_reg;
            dsince_reg   <= dsince_next;
            wdx_reg      <= wdx_next;
            hh_est_reg   <= hh_est_next;
            quad_est_reg <= quad_est_next;
            wq_est_reg   <= wq_est_next;
            err3_reg     <= err2_reg;
        end
    end

    // Stage 4: remainder corrections for hour, cycle and weekday.
    logic [16:0] hour_rem;
    logic [15:0] quad_rem;
    logic [16:0] week_rem;
    logic [4:0]  hh_next, hh4_reg;
    logic [11:0] msec_next, msec4_reg;
    logic [5:0]  quad_next, quad4_reg;
    logic [10:0] qday_next, qday4_reg;
    logic [2:0]  wd_next, wd4_reg;
    logic [16:0] week_mod;
    logic        err4_reg;

    always_comb
    begin
        hour_rem = sod3_reg - 17'(hh_est_reg) * 17'(uebd_pkg::SECS_PER_HOUR);
        if (hour_rem >= 17'(uebd_pkg::SECS_PER_HOUR))
        begin
            hh_next   = hh_est_reg + 5'd1;
            msec_next = 12'(hour_rem - 17'(uebd_pkg::SECS_PER_HOUR));
        end
        else
        begin
            hh_next   = hh_est_reg;
            msec_next = 12'(hour_rem);
        end

        quad_rem = dsince_reg - 16'(quad_est_reg) * 16'(uebd_pkg::QUAD_DAYS);
        if (quad_rem >= 16'(uebd_pkg::QUAD_DAYS))
        begin
            quad_next = quad_est_reg + 6'd1;
            qday_next = 11'(quad_rem - 16'(uebd_pkg::QUAD_DAYS));
        end
        else
        begin
            quad_next = quad_est_reg;
            qday_next = 11'(quad_rem);
        end

        week_rem = wdx_reg - 17'(wq_est_reg) * 17'(uebd_pkg::WEEK_DAYS);
        if (week_rem >= 17'(uebd_pkg::WEEK_DAYS))
        begin
            week_mod = week_rem - 17'(uebd_pkg::WEEK_DAYS);
        end
        else
        begin
            week_mod = week_rem;
        end
        wd_next = week_mod[2:0] + 3'd1;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hh4_reg   <= hh_next;
            msec4_reg <= msec_next;
            quad4_reg <= quad_next;
            qday4_reg <= qday_next;
            wd4_reg   <= wd_next;
            err4_reg  <= err3_reg;
        end
    end

    // Stage 5: year inside the cycle, day of year, minute estimate.
    logic [24:0] min_prod;
    logic [5:0]  mi_est_next, mi_est5_reg;
    logic [1:0]  yq;
    logic [10:0] yq_base;
    logic [8:0]  doy_next, doy5_reg;
    logic [7:0]  year_next, year5_reg;
    logic        leap_next, leap5_reg;
    logic [4:0]  hh5_reg;
    logic [11:0] msec5_reg;
    logic [2:0]  wd5_reg;
    logic        err5_reg;

    always_comb
    begin
        min_prod    = 25'(msec4_reg) * 25'(uebd_pkg::MIN_RECIP);
        mi_est_next = min_prod[23:18];

        if (qday4_reg < uebd_pkg::QUAD_Y1)
        begin
            yq      = 2'd0;
            yq_base = 11'd0;
        end
        else if (qday4_reg < uebd_pkg::QUAD_Y2)
        begin
            yq      = 2'd1;
            yq_base = uebd_pkg::QUAD_Y1;
        end
        else if (qday4_reg < uebd_pkg::QUAD_Y3)
        begin
            yq      = 2'd2;
            yq_base = uebd_pkg::QUAD_Y2;
        end
        else
        begin
            yq      = 2'd3;
            yq_base = uebd_pkg::QUAD_Y3;
        end
        doy_next  = 9'(qday4_reg - yq_base);
        leap_next = (yq == 2'd0);
        year_next = {quad4_reg, yq};
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mi_est5_reg <= mi_est_next;
            doy5_reg    <= doy_next;
            year5_reg   <= year_next;
            leap5_reg   <= leap_next;
            hh5_reg     <= hh4_reg;
            msec5_reg   <= msec4_reg;
            wd5_reg     <= wd4_reg;
            err5_reg    <= err4_reg;
        end
    end

    // Stage 6: minute and second, month and day of month.
    logic [11:0] min_rem;
    logic [5:0]  mi_next, mi6_reg;
    logic [5:0]  ss_next, ss6_reg;
    logic [3:0]  mcount;
    logic [8:0]  mstart;
    logic [8:0]  mbase;
    logic [3:0]  mo_next, mo6_reg;
    logic [4:0]  dd_next, dd6_reg;
    logic [7:0]  year6_reg;
    logic [4:0]  hh6_reg;
    logic [2:0]  wd6_reg;
    logic        err6_reg;

    always_comb
    begin
        min_rem = msec5_reg - 12'(mi_est5_reg) * 12'(uebd_pkg::SECS_PER_MIN);
        if (min_rem >= 12'(uebd_pkg::SECS_PER_MIN))
        begin
            mi_next = mi_est5_reg + 6'd1;
            ss_next = 6'(min_rem - 12'(uebd_pkg::SECS_PER_MIN));
        end
        else
        begin
            mi_next = mi_est5_reg;
            ss_next = 6'(min_rem);
        end

        // Count month boundaries already passed; leap years shift March onward.
        mcount = 4'd0;
        mstart = 9'd0;
        for (int i = 1; i < 12; i++)
        begin
            mstart = uebd_pkg::MONTH_START[i] + 9'((i >= 2) && leap5_reg);
            if (doy5_reg >= mstart)
            begin
                mcount = mcount + 4'd1;
            end
        end
        mbase   = uebd_pkg::MONTH_START[mcount] + 9'((mcount >= 4'd2) && leap5_reg);
        dd_next = 5'(doy5_reg - mbase) + 5'd1;
        mo_next = mcount + 4'd1;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mi6_reg   <= mi_next;
            ss6_reg   <= ss_next;
            mo6_reg   <= mo_next;
            dd6_reg   <= dd_next;
            year6_reg <= year5_reg;
            hh6_reg   <= hh5_reg;
            wd6_reg   <= wd5_reg;
            err6_reg  <= err5_reg;
        end
    end

    // Stage 7: BCD packing and zeroing of out-of-range results.
    logic [7:0] ss_bcd, mi_bcd, hh_bcd, dd_bcd, mo_bcd, yr_bcd;
    logic [6:0] seconds_next, seconds_reg;
    logic [6:0] minutes_next, minutes_reg;
    logic [5:0] hours_next, hours_reg;
    logic [2:0] weekday_next, weekday_reg;
    logic [5:0] date_next, date_reg;
    logic [4:0] month_next, month_reg;
    logic [7:0] year_bcd_next, year_reg;
    logic       range_error_reg;

    always_comb
    begin
        ss_bcd = uebd_pkg::to_bcd(8'(ss6_reg));
        mi_bcd = uebd_pkg::to_bcd(8'(mi6_reg));
        hh_bcd = uebd_pkg::to_bcd(8'(hh6_reg));
        dd_bcd = uebd_pkg::to_bcd(8'(dd6_reg));
        mo_bcd = uebd_pkg::to_bcd(8'(mo6_reg));
        yr_bcd = uebd_pkg::to_bcd(year6_reg);
        if (err6_reg)
        begin
            seconds_next  = '0;
            minutes_next  = '0;
            hours_next    = '0;
            weekday_next  = '0;
            date_next     = '0;
            month_next    = '0;
            year_bcd_next = '0;
        end
        else
        begin
            seconds_next  = ss_bcd[6:0];
            minutes_next  = mi_bcd[6:0];
            hours_next    = hh_bcd[5:0];
            weekday_next  = wd6_reg;
            date_next     = dd_bcd[5:0];
            month_next    = mo_bcd[4:0];
            year_bcd_next = yr_bcd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            seconds_reg     <= seconds_next;
            minutes_reg     <= minutes_next;
            hours_reg       <= hours_next;
            weekday_reg     <= weekday_next;
            date_reg        <= date_next;
            month_reg       <= month_next;
            year_reg        <= year_bcd_next;
            range_error_reg <= err6_reg;
        end
    end

    // Output channel.
    assign rtc.valid       = valid_reg[6];
    assign rtc.seconds_bcd = seconds_reg;
    assign rtc.minutes_bcd = minutes_reg;
    assign rtc.hours_bcd   = hours_reg;
    assign rtc.weekday_bcd = weekday_reg;
    assign rtc.date_bcd    = date_reg;
    assign rtc.month_bcd   = month_reg;
    assign rtc.year_bcd    = year_reg;
    assign rtc.range_error = range_error_reg;

    // An out-of-range result carries all-zero fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rtc.valid && rtc.range_error) |-> (rtc.seconds_bcd == '0 && rtc.minutes_bcd == '0
            && rtc.hours_bcd == '0 && rtc.weekday_bcd == '0 && rtc.date_bcd == '0
            && rtc.month_bcd == '0 && rtc.year_bcd == '0))
        else $error("range error result has nonzero fields");

    // A valid in-range result has a weekday from 1 to 7 and a nonzero month and date.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rtc.valid && !rtc.range_error) |-> (rtc.weekday_bcd != 3'd0
            && rtc.month_bcd != 5'd0 && rtc.date_bcd != 6'd0))
        else $error("in-range result has a zero weekday, month or date");

    // Seconds and minutes digits stay decimal.
    assert property (@(posedge clk) disable iff (!rst_n)
        rtc.valid |-> (rtc.seconds_bcd[3:0] <= 4'd9 && rtc.minutes_bcd[3:0] <= 4'd9
            && rtc.seconds_bcd[6:4] <= 3'd5 && rtc.minutes_bcd[6:4] <= 3'd5))
        else $error("seconds or minutes out of BCD range");

    // A waiting result blocks new input.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rtc.valid && !rtc.ready) |-> !epoch.ready)
        else $error("input accepted while output stalled");

    // An accepted epoch occupies stage one in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (epoch.valid && epoch.ready) |-> ##1 (valid_reg[0] || !advance))
        else $error("accepted transaction lost in stage one");

endmodule

@@ bench/rtc_image_checker.sv @@
`timescale 1ns / 1ps
// Checker for the epoch to BCD date/time converter: predicts the RTC image of
// every accepted epoch and compares it with the results. Depends on uebd_if.sv.
module rtc_image_checker (
    input  logic   clk,
    uebd_epoch_if  epoch,
    uebd_rtc_if    rtc,
    output int     mismatch_count,
    output int     awaited_count
);

    localparam int unsigned SECS_PER_DAY  = 86400;
    localparam int unsigned SECS_PER_HOUR = 3600;
    localparam int unsigned SECS_PER_MIN  = 60;
    // Days from 0000-03-01 to 1970-01-01 in the proleptic Gregorian calendar.
    localparam int unsigned MARCH_SHIFT   = 719468;
    localparam int unsigned ERA_LENGTH    = 146097;
    localparam int unsigned FIRST_YEAR    = 2000;
    localparam int unsigned LAST_YEAR     = 2099;

    typedef struct packed {
        logic [6:0] seconds_bcd;
        logic [6:0] minutes_bcd;
        logic [5:0] hours_bcd;
        logic [2:0] weekday_bcd;
        logic [5:0] date_bcd;
        logic [4:0] month_bcd;
        logic [7:0] year_bcd;
        logic       range_error;
    } rtc_image_t;

    rtc_image_t expected_images[$];
    int         errors = 0;

    // Packs a value below 100 into two BCD digits, tens in the upper nibble.
    function automatic logic [7:0] bcd_pair(input int unsigned v);
        return 8'((((v / 10) % 10) << 4) | (v % 10));
    endfunction

    // Civil date and time of an epoch count, laid out as the RTC image.
    function automatic rtc_image_t civil_time_of(input logic [31:0] epoch_value);
        int unsigned secs, days, sod, z, era, doe, yoe, doy, mp, dd, mo, yr, wd;
        rtc_image_t  img;
        secs = epoch_value;
        days = secs / SECS_PER_DAY;
        sod  = secs % SECS_PER_DAY;

        // Eras of 400 years whose years start in March.
        z   = days + MARCH_SHIFT;
        era = z / ERA_LENGTH;
        doe = z - era * ERA_LENGTH;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp  = (5 * doy + 2) / 153;
        dd  = doy - (153 * mp + 2) / 5 + 1;
        mo  = (mp < 10) ? mp + 3 : mp - 9;
        yr  = yoe + era * 400 + ((mo <= 2) ? 1 : 0);
        // The epoch day was a Thursday, which is 5 when Sunday is 1.
        wd  = (days + 4) % 7 + 1;

        img = '0;
        if (yr < FIRST_YEAR || yr > LAST_YEAR) begin
            img.range_error = 1'b1;
            return img;
        end
        img.seconds_bcd = 7'(bcd_pair(sod % SECS_PER_MIN));
        img.minutes_bcd = 7'(bcd_pair((sod % SECS_PER_HOUR) / SECS_PER_MIN));
        img.hours_bcd   = 6'(bcd_pair(sod / SECS_PER_HOUR));
        img.weekday_bcd = 3'(wd);
        img.date_bcd    = 6'(bcd_pair(dd));
        img.month_bcd   = 5'(bcd_pair(mo));
        img.year_bcd    = bcd_pair(yr - FIRST_YEAR);
        return img;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
            errors++;
        end
    endfunction

    // Expectations are queued on accepted epochs and consumed by accepted results.
    always @(posedge clk) begin
        rtc_image_t want;
        if (epoch.valid === 1'b1 && epoch.ready === 1'b1)
            expected_images.push_back(civil_time_of(epoch.epoch_seconds));
        if (rtc.valid === 1'b1 && rtc.ready === 1'b1) begin
            if (expected_images.size() == 0) begin
                $error("rtc transaction with no epoch awaiting its result");
                errors++;
            end
            else begin
                want = expected_images.pop_front();
                check_field("seconds_bcd", 32'(want.seconds_bcd), 32'(rtc.seconds_bcd));
                check_field("minutes_bcd", 32'(want.minutes_bcd), 32'(rtc.minutes_bcd));
                check_field("hours_bcd", 32'(want.hours_bcd), 32'(rtc.hours_bcd));
                check_field("weekday_bcd", 32'(want.weekday_bcd), 32'(rtc.weekday_bcd));
                check_field("date_bcd", 32'(want.date_bcd), 32'(rtc.date_bcd));
                check_field("month_bcd", 32'(want.month_bcd), 32'(rtc.month_bcd));
                check_field("year_bcd", 32'(want.year_bcd), 32'(rtc.year_bcd));
                check_field("range_error", 32'(want.range_error), 32'(rtc.range_error));
            end
        end
        mismatch_count <= errors;
        awaited_count  <= expected_images.size();
    end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// Top of the epoch to BCD date/time converter bench: clock, reset, epoch stimulus,
// receiver stalls and the verdict. Depends on uebd_if.sv and rtc_image_checker.
module testbench;

    localparam logic [31:0] EPOCH_Y2000   = 32'd946684800;
    localparam logic [31:0] EPOCH_Y2100   = 32'd4102444800;
    localparam int unsigned DAY_SECONDS   = 86400;
    localparam int unsigned CENTURY_DAYS  = 36525;
    localparam int          RANDOM_ITEMS  = 1550;
    localparam int          IDLE_PERCENT  = 18;

    logic clk;
    logic rst_n;
    logic steady;
    int   mismatch_count;
    int   awaited_count;

    uebd_epoch_if epoch_ch ();
    uebd_rtc_if   rtc_ch ();

    unix_epoch_to_bcd_datetime dut (
        .clk   (clk),
        .rst_n (rst_n),
        .epoch (epoch_ch),
        .rtc   (rtc_ch)
    );

    rtc_image_checker checker_i (
        .clk            (clk),
        .epoch          (epoch_ch),
        .rtc            (rtc_ch),
        .mismatch_count (mismatch_count),
        .awaited_count  (awaited_count)
    );

    // Directed epochs: field extremes, range edges, leap days and month ends.
    logic [31:0] directed_epochs [] = '{
        32'd0, 32'hFFFF_FFFF, 32'd946684799, 32'd946684800,
        32'd4102444799, 32'd4102444800, 32'd4102358400, 32'd951782399,
        32'd951782400, 32'd951868800, 32'd978220800, 32'd983404799,
        32'd983404800, 32'd1709164800, 32'd1709251199, 32'd946771200,
        32'd1234567890, 32'd2147483647, 32'd2147483648, 32'h5555_5555,
        32'hAAAA_AAAA, 32'd4102444801
    };

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit, far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Receiver: random stalls, quiet during the steady stretch, and two long
    // hold-offs while the sender keeps offering epochs.
    initial begin
        int rx_cycle;
        rx_cycle = 0;
        rtc_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            rx_cycle++;
            if ((rx_cycle >= 900 && rx_cycle < 964) || (rx_cycle >= 1800 && rx_cycle < 1840))
                rtc_ch.ready <= 1'b0;
            else if (steady)
                rtc_ch.ready <= 1'b1;
            else
                rtc_ch.ready <= ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Offers one epoch, after a random idle gap, and waits until it is taken.
    task automatic send_epoch(input logic [31:0] value);
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            @(negedge clk);
            epoch_ch.valid         <= 1'b0;
            epoch_ch.epoch_seconds <= $urandom;
        end
        @(negedge clk);
        epoch_ch.valid         <= 1'b1;
        epoch_ch.epoch_seconds <= value;
        do
            @(posedge clk);
        while (epoch_ch.ready !== 1'b1);
    endtask

    // A random epoch, mostly inside the supported century, often right at the
    // start or end of a day so that month and year rollovers are hit.
    function automatic logic [31:0] random_epoch();
        int unsigned pick;
        logic [31:0] day_start;
        pick = $urandom_range(99);
        if (pick < 50)
            return $urandom_range(EPOCH_Y2100 - 1, EPOCH_Y2000);
        if (pick < 80) begin
            day_start = EPOCH_Y2000 + $urandom_range(CENTURY_DAYS - 1) * DAY_SECONDS;
            if ($urandom_range(1))
                return day_start + $urandom_range(59);
            return day_start + DAY_SECONDS - 1 - $urandom_range(59);
        end
        return $urandom;
    endfunction

    initial begin
        rst_n                  = 1'b0;
        steady                 = 1'b0;
        epoch_ch.valid         = 1'b0;
        epoch_ch.epoch_seconds = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_epochs[i])
            send_epoch(directed_epochs[i]);

        // Random part, with a stretch where neither side idles.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady = (n >= 700 && n < 950);
            send_epoch(random_epoch());
        end
        steady = 1'b0;
        @(negedge clk);
        epoch_ch.valid <= 1'b0;

        // Drain, then allow for the seven-stage pipeline to settle.
        while (awaited_count != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatch_count == 0 && awaited_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
